// ===== rtl/prn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the printf number renderer.
package prn_pkg;

    typedef enum logic [2:0] {
        CMD_PCT  = 3'd0,
        CMD_SDEC = 3'd1,
        CMD_OCT  = 3'd2,
        CMD_UDEC = 3'd3,
        CMD_HEXL = 3'd4,
        CMD_HEXU = 3'd5,
        CMD_CHAR = 3'd6,
        CMD_PTR  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        SZ_INT  = 2'd0,
        SZ_LONG = 2'd1,
        SZ_LL   = 2'd2
    } t_size;

    typedef enum logic {
        K_CHAR = 1'b0,
        K_NUM  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        P_NONE  = 2'd0,
        P_MINUS = 2'd1,
        P_HEX   = 2'd2
    } t_pfx;

    typedef enum logic [1:0] {
        RX_OCT = 2'd0,
        RX_DEC = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    // one classified conversion, as held in the queue
    typedef struct packed {
        t_kind       kind;
        t_pfx        pfx;
        t_radix      radix;
        logic        upper;
        logic [7:0]  chr;
        logic [63:0] mag;
        logic        start_new;
    } t_entry;

    localparam int CAP_W       = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int NDIG        = 22;   // octal digits of a 64-bit value
    localparam int NBCD        = 20;   // decimal digits of a 64-bit value
    localparam int DIG_IDX_W   = 5;
    localparam int DD_STEPS    = 64;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            return CH_ZERO + {4'b0, d};
        end
        return base + {4'b0, d} - 8'd10;
    endfunction

endpackage

// ===== rtl/prn_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for conversion items and output characters.
interface prn_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [1:0]  size_mode;
    logic [63:0] arg_value;
    logic        start_new;

    modport source(output valid, command, size_mode, arg_value, start_new, input ready);
    modport sink(input valid, command, size_mode, arg_value, start_new, output ready);
endinterface

interface prn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source(output valid, out_char, last, input ready);
    modport sink(input valid, out_char, last, output ready);
endinterface

// ===== rtl/prn_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts conversion items and classifies them into queue entries.
module prn_front import prn_pkg::*; (
    prn_in_if.sink   i_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_entry   o_entry
);

    t_cmd        cmd;
    logic        wide;
    logic [63:0] val;
    logic        neg;

    assign cmd  = t_cmd'(i_item.command);
    assign wide = (i_item.size_mode != SZ_INT);
    assign val  = wide ? i_item.arg_value : {32'b0, i_item.arg_value[31:0]};
    assign neg  = wide ? val[63] : val[31];

    assign i_item.ready = !i_q_full;
    assign o_push       = i_item.valid && !i_q_full;

    always_comb begin
        o_entry           = '0;
        o_entry.kind      = K_NUM;
        o_entry.pfx       = P_NONE;
        o_entry.radix     = RX_DEC;
        o_entry.upper     = 1'b0;
        o_entry.chr       = CH_PCT;
        o_entry.mag       = val;
        o_entry.start_new = i_item.start_new;
        case (cmd)
            CMD_PCT: begin
                o_entry.kind = K_CHAR;
                o_entry.chr  = CH_PCT;
            end
            CMD_SDEC: begin
                if (neg) begin
                    o_entry.pfx = P_MINUS;
                    // narrow minimum negates to 0x80000000, which is its magnitude
                    o_entry.mag = wide ? (64'd0 - val) : {32'b0, 32'd0 - val[31:0]};
                end
            end
            CMD_OCT:  o_entry.radix = RX_OCT;
            CMD_UDEC: o_entry.radix = RX_DEC;
            CMD_HEXL: o_entry.radix = RX_HEX;
            CMD_HEXU: begin
                o_entry.radix = RX_HEX;
                o_entry.upper = 1'b1;
            end
            CMD_CHAR: begin
                o_entry.kind = K_CHAR;
                o_entry.chr  = i_item.arg_value[7:0];
            end
            CMD_PTR: begin
                o_entry.pfx   = P_HEX;
                o_entry.radix = RX_HEX;
                o_entry.mag   = i_item.arg_value;
            end
            default: o_entry.kind = K_CHAR;
        endcase
    end

endmodule

// ===== rtl/prn_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified entries between the front and back ends.
module prn_queue import prn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QPTR_W:0]     r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

// ===== rtl/prn_back.sv =====
`timescale 1ns / 1ps
// Back end: digit conversion, space accounting and character output.
module prn_back import prn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CAP_W-1:0] i_cap,
    input  logic             i_q_valid,
    input  t_entry           i_q_entry,
    output logic             o_q_pop,
    prn_out_if.source        o_char
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE1,
        ST_PRE2,
        ST_CONV,
        ST_EMIT
    } t_state;

    localparam logic [DIG_IDX_W-1:0] IDX_OCT = DIG_IDX_W'(NDIG - 1);
    localparam logic [DIG_IDX_W-1:0] IDX_DEC = DIG_IDX_W'(NBCD - 1);
    localparam logic [DIG_IDX_W-1:0] IDX_HEX = DIG_IDX_W'(15);

    t_state                r_state, n_state;
    logic [CAP_W-1:0]      r_space, n_space;
    t_entry                r_ent, n_ent;
    logic [63:0]           r_mag, n_mag;
    logic [3:0]            r_dig [NDIG];
    logic [3:0]            n_dig [NDIG];
    logic [5:0]            r_cnt, n_cnt;
    logic [DIG_IDX_W-1:0]  r_idx, n_idx;
    logic                  r_started, n_started;
    logic                  r_ov, n_ov;
    logic [7:0]            r_oc, n_oc;
    logic                  r_ol, n_ol;

    logic [3:0]            adj [NBCD];
    logic [3:0]            dd [NDIG];
    logic [3:0]            ld_oct [NDIG];
    logic [3:0]            ld_hex [NDIG];
    logic [65:0]           mag_ext;
    logic                  can_emit;
    logic                  space_one;
    logic                  pre_fin;
    logic [7:0]            pre_char;
    logic [3:0]            cur_dig;

    assign o_char.valid    = r_ov;
    assign o_char.out_char = r_oc;
    assign o_char.last     = r_ol;
    assign o_q_pop         = (r_state == ST_IDLE);

    assign can_emit  = !r_ov || o_char.ready;
    assign space_one = (r_space == CAP_W'(1));
    assign mag_ext   = {2'b0, r_mag};
    assign cur_dig   = r_dig[r_idx];
    assign pre_fin   = (r_ent.kind == K_CHAR);

    always_comb begin
        if (r_ent.kind == K_CHAR) begin
            pre_char = r_ent.chr;
        end else if (r_ent.pfx == P_MINUS) begin
            pre_char = CH_MINUS;
        end else begin
            pre_char = CH_ZERO;
        end
    end

    // shift-and-add-3 step: adjust every BCD digit, then shift in the next magnitude bit
    always_comb begin
        for (int i = 0; i < NBCD; i++) begin
            adj[i] = (r_dig[i] >= 4'd5) ? (r_dig[i] + 4'd3) : r_dig[i];
        end
        for (int i = 0; i < NDIG; i++) begin
            dd[i] = '0;
        end
        dd[0] = {adj[0][2:0], r_mag[63]};
        for (int i = 1; i < NBCD; i++) begin
            dd[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            ld_oct[i] = {1'b0, mag_ext[3*i +: 3]};
            ld_hex[i] = '0;
        end
        for (int i = 0; i < 16; i++) begin
            ld_hex[i] = r_mag[4*i +: 4];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_space   = r_space;
        n_ent     = r_ent;
        n_mag     = r_mag;
        n_dig     = r_dig;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_started = r_started;
        n_ov      = r_ov && !o_char.ready;
        n_oc      = r_oc;
        n_ol      = r_ol;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_ent     = i_q_entry;
                    n_mag     = i_q_entry.mag;
                    n_cnt     = '0;
                    n_started = 1'b0;
                    for (int i = 0; i < NDIG; i++) begin
                        n_dig[i] = '0;
                    end
                    if (i_q_entry.start_new) begin
                        n_space = i_cap;
                    end
                    if (i_q_entry.kind == K_CHAR || i_q_entry.pfx != P_NONE) begin
                        n_state = ST_PRE1;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_PRE1: begin
                if (r_space == '0) begin
                    n_state = ST_IDLE;
                end else if (can_emit) begin
                    n_ov    = 1'b1;
                    n_oc    = pre_char;
                    n_ol    = pre_fin || space_one;
                    n_space = r_space - 1'b1;
                    if (pre_fin || space_one) begin
                        n_state = ST_IDLE;
                    end else if (r_ent.pfx == P_HEX) begin
                        n_state = ST_PRE2;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_PRE2: begin
                if (r_space == '0) begin
                    n_state = ST_IDLE;
                end else if (can_emit) begin
                    n_ov    = 1'b1;
                    n_oc    = CH_X;
                    n_ol    = space_one;
                    n_space = r_space - 1'b1;
                    n_state = space_one ? ST_IDLE : ST_CONV;
                end
            end
            ST_CONV: begin
                case (r_ent.radix)
                    RX_DEC: begin
                        n_dig = dd;
                        n_mag = {r_mag[62:0], 1'b0};
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == 6'(DD_STEPS - 1)) begin
                            n_idx   = IDX_DEC;
                            n_state = ST_EMIT;
                        end
                    end
                    RX_OCT: begin
                        n_dig   = ld_oct;
                        n_idx   = IDX_OCT;
                        n_state = ST_EMIT;
                    end
                    default: begin
                        n_dig   = ld_hex;
                        n_idx   = IDX_HEX;
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT: begin
                if (r_space == '0) begin
                    n_state = ST_IDLE;
                end else if (!r_started && cur_dig == 4'd0 && r_idx != '0) begin
                    // leading zero
                    n_idx = r_idx - 1'b1;
                end else if (can_emit) begin
                    n_started = 1'b1;
                    n_ov      = 1'b1;
                    n_oc      = digit_char(cur_dig, r_ent.upper);
                    n_ol      = (r_idx == '0) || space_one;
                    n_space   = r_space - 1'b1;
                    n_idx     = r_idx - 1'b1;
                    if (r_idx == '0 || space_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_space   <= CAP_RESET;
            r_ov      <= 1'b0;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_space   <= n_space;
            r_ov      <= n_ov;
            r_started <= n_started;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
        end
        r_ent <= n_ent;
        r_mag <= n_mag;
        r_dig <= n_dig;
        r_oc  <= n_oc;
        r_ol  <= n_ol;
    end

endmodule

// ===== rtl/printf_number_renderer_core.sv =====
`timescale 1ns / 1ps
// Top level of the printf number renderer: capacity register, front, queue, back.
//
//  channel   dir  handshake     payload
//  i_item    in   valid/ready   command[2:0] size_mode[1:0] arg_value[63:0] start_new
//  o_char    out  valid/ready   out_char[7:0] last
//  i_cfg_*   in   write enable  buffer_capacity[15:0]
//
// The front end classifies an item in the cycle it is transferred and queues it
// (two entries). The back end takes one queued item at a time: a pop, then any
// prefix or single character, then octal/hex digits load in a single step while
// decimal runs shift-add-3 steps, one per magnitude bit; emission scans 16/20/22
// digit slots for hex/decimal/octal, skipping leading zeros.
// Reset is synchronous, active low; space left and capacity reset to 65535.
// A stalled o_char holds the back end; the front end keeps accepting until the
// queue is full.
module printf_number_renderer_core import prn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    prn_in_if.sink           i_item,
    prn_out_if.source        o_char
);

    logic [CAP_W-1:0] r_cap;
    logic             q_push;
    t_entry           q_in;
    logic             q_full;
    logic             q_valid;
    t_entry           q_out;
    logic             q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    prn_front u_front (
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    prn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    prn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cap     (r_cap),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_char    (o_char)
    );

endmodule
